// ===== sv/dinic_max_flow_engine_macros.svh =====
// Assertion macros used by the checker of the max flow engine.
`ifndef DINIC_MAX_FLOW_ENGINE_MACROS_SVH
`define DINIC_MAX_FLOW_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while the reset is asserted.
`define DMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the reset is asserted.
`define DMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across the reset.
`define DMF_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dmf_pkg.sv =====
// Shared constants, types and helpers of the max flow engine.
`timescale 1ns / 1ps
package dmf_pkg;

    localparam int DMF_VERTEX_COUNT = 64;
    localparam int DMF_VID_W        = 6;
    localparam int DMF_CAP_W        = 16;
    localparam int DMF_RES_W        = 32;
    localparam int DMF_FLOW_W       = 40;

    localparam logic [DMF_RES_W-1:0]  DMF_BOTTLENECK_START = 32'd100000000;
    localparam logic [DMF_FLOW_W-1:0] DMF_TOTAL_MAX        = 40'hFF_FFFF_FFFF;
    localparam logic [DMF_VID_W-1:0]  DMF_SOURCE_RESET     = 6'd0;
    localparam logic [DMF_VID_W-1:0]  DMF_SINK_RESET       = 6'd25;

    // Configuration register indexes.
    localparam logic DMF_CFG_SOURCE = 1'b0;
    localparam logic DMF_CFG_SINK   = 1'b1;

    // Port enables of the residual matrix memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    // Residual addition that saturates at the top of the entry range.
    function automatic logic [DMF_RES_W-1:0] sat_add32(input logic [DMF_RES_W-1:0] a,
                                                        input logic [DMF_RES_W-1:0] b);
        logic [DMF_RES_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DMF_RES_W] ? {DMF_RES_W{1'b1}} : s[DMF_RES_W-1:0];
    endfunction

endpackage

// ===== sv/dinic_max_flow_engine.sv =====
// Edge loading does one residual read and write per direction for each transaction.
// A last edge then runs the max flow search: a level search from the source, then a
// blocking flow search that augments each path it finds, repeated phase by phase.
// After each result, and after reset, the matrix is cleared one entry per cycle over
// all 2**(2*clog2(VERTEX_COUNT)) entries, 4096 at 64 vertices, with no edge taken meanwhile.
// Reset is synchronous and active low; source resets to 0 and sink to 25.
`timescale 1ns / 1ps
module dinic_max_flow_engine
    import dmf_pkg::*;
#(
    parameter int VERTEX_COUNT = DMF_VERTEX_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // from_vertex [5:0], to_vertex [11:6], edge_capacity [27:12], zero fill [31:28]
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // max_flow [39:0]
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [5:0]  i_cfg_data
);

    localparam int MW = 2 * $clog2(VERTEX_COUNT);

    logic [DMF_VID_W-1:0] r_src, r_snk;
    t_mem_ctl             mat_ctl;
    logic [MW-1:0]        mat_rd_addr, mat_wr_addr;
    logic [DMF_RES_W-1:0] mat_wr_data, mat_rd_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= DMF_SOURCE_RESET;
            r_snk <= DMF_SINK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                DMF_CFG_SOURCE: r_src <= i_cfg_data;
                DMF_CFG_SINK:   r_snk <= i_cfg_data;
                default:        r_src <= r_src;
            endcase
        end
    end

    dmf_ctrl #(
        .VERTEX_COUNT(VERTEX_COUNT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_from       (s_axis_tdata[5:0]),
        .i_to         (s_axis_tdata[11:6]),
        .i_cap        (s_axis_tdata[27:12]),
        .i_last       (s_axis_tlast),
        .i_src        (r_src),
        .i_snk        (r_snk),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_mat_ctl    (mat_ctl),
        .o_mat_rd_addr(mat_rd_addr),
        .o_mat_wr_addr(mat_wr_addr),
        .o_mat_wr_data(mat_wr_data),
        .i_mat_rd_data(mat_rd_data)
    );

    dmf_matrix_ram #(
        .AW(MW)
    ) u_matrix (
        .i_clk    (i_clk),
        .i_ctl    (mat_ctl),
        .i_rd_addr(mat_rd_addr),
        .i_wr_addr(mat_wr_addr),
        .i_wr_data(mat_wr_data),
        .o_rd_data(mat_rd_data)
    );

endmodule

// ===== sv/dmf_matrix_ram.sv =====
// Residual capacity matrix: one write port and one registered read port.
`timescale 1ns / 1ps
module dmf_matrix_ram
    import dmf_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic                 i_clk,
    input  t_mem_ctl             i_ctl,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [DMF_RES_W-1:0] i_wr_data,
    output logic [DMF_RES_W-1:0] o_rd_data
);

    logic [DMF_RES_W-1:0] r_mem [1 << AW];
    logic [DMF_RES_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/dmf_ctrl.sv =====
// Sequencer: edge loading, level search, blocking flow search and matrix clearing.
`timescale 1ns / 1ps
module dmf_ctrl
    import dmf_pkg::*;
#(
    parameter int VERTEX_COUNT = DMF_VERTEX_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [DMF_VID_W-1:0]  i_from,
    input  logic [DMF_VID_W-1:0]  i_to,
    input  logic [DMF_CAP_W-1:0]  i_cap,
    input  logic                  i_last,
    input  logic [DMF_VID_W-1:0]  i_src,
    input  logic [DMF_VID_W-1:0]  i_snk,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DMF_FLOW_W-1:0] o_out_data,
    output t_mem_ctl              o_mat_ctl,
    output logic [2*$clog2(VERTEX_COUNT)-1:0] o_mat_rd_addr,
    output logic [2*$clog2(VERTEX_COUNT)-1:0] o_mat_wr_addr,
    output logic [DMF_RES_W-1:0]  o_mat_wr_data,
    input  logic [DMF_RES_W-1:0]  i_mat_rd_data
);

    localparam int VW = $clog2(VERTEX_COUNT);
    localparam int LW = VW + 1;
    localparam int VD = 1 << VW;
    localparam int MW = 2 * VW;
    localparam int QW = LW + VW;

    localparam logic [LW-1:0] VC_L   = LW'(VERTEX_COUNT);
    localparam logic [LW-1:0] VC_M1  = LW'(VERTEX_COUNT - 1);
    localparam logic [8:0]    VC_CMP = 9'(VERTEX_COUNT);

    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_LD_R1    = 5'd2;
    localparam logic [4:0] S_LD_W1    = 5'd3;
    localparam logic [4:0] S_LD_R2    = 5'd4;
    localparam logic [4:0] S_LD_W2    = 5'd5;
    localparam logic [4:0] S_START    = 5'd6;
    localparam logic [4:0] S_PHASE    = 5'd7;
    localparam logic [4:0] S_BFS_POP  = 5'd8;
    localparam logic [4:0] S_BFS_U    = 5'd9;
    localparam logic [4:0] S_BFS_SCAN = 5'd10;
    localparam logic [4:0] S_BFS_DRN  = 5'd11;
    localparam logic [4:0] S_DFS_TOP  = 5'd12;
    localparam logic [4:0] S_DFS_NN   = 5'd13;
    localparam logic [4:0] S_DFS_SCAN = 5'd14;
    localparam logic [4:0] S_DFS_CHK  = 5'd15;
    localparam logic [4:0] S_DFS_POP  = 5'd16;
    localparam logic [4:0] S_AUG_RD   = 5'd17;
    localparam logic [4:0] S_AUG_B    = 5'd18;
    localparam logic [4:0] S_AUG_W1   = 5'd19;
    localparam logic [4:0] S_AUG_R2   = 5'd20;
    localparam logic [4:0] S_AUG_W2   = 5'd21;
    localparam logic [4:0] S_DONE     = 5'd22;

    // Control registers and their next values.
    logic [4:0]            r_state, n_state;
    logic [MW-1:0]         r_clr, n_clr;
    logic [VW-1:0]         r_u, n_u, r_v, n_v;
    logic [DMF_CAP_W-1:0]  r_c, n_c;
    logic                  r_last, n_last, r_inr, n_inr;
    logic [VD-1:0]         r_lv, n_lv, r_nnv, n_nnv;
    logic [LW-1:0]         r_head, n_head, r_tail, n_tail, r_scan, n_scan;
    logic [VW-1:0]         r_bu, n_bu, r_pvv, n_pvv;
    logic [LW-1:0]         r_blev, n_blev;
    logic                  r_pv, n_pv;
    logic [VW-1:0]         r_depth, n_depth, r_cu, n_cu;
    logic [DMF_RES_W-1:0]  r_bn, n_bn;
    logic                  r_inc, n_inc;
    logic [LW-1:0]         r_ptr, n_ptr;
    logic [VW-1:0]         r_ai, n_ai, r_a, n_a, r_b, n_b;
    logic [DMF_FLOW_W-1:0] r_flow, n_flow, r_odata, n_odata;
    logic                  r_oval, n_oval;

    // Scratch memories with registered reads.
    logic [QW-1:0]        r_q_mem [VD];
    logic [LW-1:0]        r_lev_mem [VD];
    logic [LW-1:0]        r_nn_mem [VD];
    logic [VW-1:0]        r_stk_mem [VD];
    logic [DMF_RES_W-1:0] r_bn_mem [VD];
    logic [QW-1:0]        r_q_rd;
    logic [LW-1:0]        r_lev_rd, r_nn_rd;
    logic [VW-1:0]        r_stk_rd;
    logic [DMF_RES_W-1:0] r_bn_rd;

    logic                 q_we, lev_we, nn_we, stk_we, bn_we;
    logic [VW-1:0]        q_wa, q_ra, lev_wa, lev_ra, nn_wa, nn_ra;
    logic [VW-1:0]        stk_wa, stk_ra, bn_wa, bn_ra;
    logic [QW-1:0]        q_wd;
    logic [LW-1:0]        lev_wd, nn_wd;
    logic [VW-1:0]        stk_wd;
    logic [DMF_RES_W-1:0] bn_wd;

    logic                  accept, ends_ok, adm, retreat;
    logic [VW-1:0]         src_v, snk_v, ptr_v;
    logic [LW-1:0]         nn_start;
    logic [DMF_RES_W-1:0]  cand_bn;
    logic [DMF_FLOW_W:0]   flow_sum;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_oval;
    assign o_out_data  = r_odata;

    assign src_v   = VW'(i_src);
    assign snk_v   = VW'(i_snk);
    assign ends_ok = ({3'b000, i_src} < VC_CMP) && ({3'b000, i_snk} < VC_CMP)
                     && (i_src != i_snk);
    assign ptr_v    = r_ptr[VW-1:0];
    assign nn_start = (r_nnv[r_cu] ? r_nn_rd : '0) + LW'(r_inc);
    assign cand_bn  = (i_mat_rd_data < r_bn) ? i_mat_rd_data : r_bn;
    assign adm      = r_lv[ptr_v] && (r_lev_rd == (LW'(r_depth) + LW'(1)))
                      && (i_mat_rd_data != '0);
    assign flow_sum = {1'b0, r_flow} + (DMF_FLOW_W + 1)'(r_bn);

    // Next-state and memory port logic.
    always_comb begin
        n_state = r_state; n_clr = r_clr; n_u = r_u; n_v = r_v; n_c = r_c;
        n_last = r_last; n_inr = r_inr; n_lv = r_lv; n_nnv = r_nnv;
        n_head = r_head; n_tail = r_tail; n_scan = r_scan; n_bu = r_bu;
        n_pvv = r_pvv; n_blev = r_blev; n_pv = 1'b0; n_depth = r_depth;
        n_cu = r_cu; n_bn = r_bn; n_inc = r_inc; n_ptr = r_ptr; n_ai = r_ai;
        n_a = r_a; n_b = r_b; n_flow = r_flow; n_odata = r_odata; n_oval = r_oval;
        retreat = 1'b0;

        o_mat_ctl     = '0;
        o_mat_rd_addr = '0;
        o_mat_wr_addr = '0;
        o_mat_wr_data = '0;
        q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
        lev_we = 1'b0; lev_wa = '0; lev_wd = '0; lev_ra = '0;
        nn_we = 1'b0; nn_wa = '0; nn_wd = '0; nn_ra = '0;
        stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
        bn_we = 1'b0; bn_wa = '0; bn_wd = '0; bn_ra = '0;

        // The result register empties when its transaction completes.
        if (r_oval && i_out_ready) begin
            n_oval = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                o_mat_ctl.wr_en = 1'b1;
                o_mat_wr_addr   = r_clr;
                n_clr           = r_clr + MW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_u     = VW'(i_from);
                    n_v     = VW'(i_to);
                    n_c     = i_cap;
                    n_last  = i_last;
                    n_inr   = ({3'b000, i_from} < VC_CMP) && ({3'b000, i_to} < VC_CMP);
                    n_state = S_LD_R1;
                end
            end
            S_LD_R1: begin
                if (r_inr) begin
                    o_mat_ctl.rd_en = 1'b1;
                    o_mat_rd_addr   = {r_u, r_v};
                    n_state         = S_LD_W1;
                end else begin
                    n_state = r_last ? S_START : S_IDLE;
                end
            end
            S_LD_W1: begin
                o_mat_ctl.wr_en = 1'b1;
                o_mat_wr_addr   = {r_u, r_v};
                o_mat_wr_data   = sat_add32(i_mat_rd_data, DMF_RES_W'(r_c));
                if (r_u != r_v) begin
                    n_state = S_LD_R2;
                end else begin
                    n_state = r_last ? S_START : S_IDLE;
                end
            end
            S_LD_R2: begin
                o_mat_ctl.rd_en = 1'b1;
                o_mat_rd_addr   = {r_v, r_u};
                n_state         = S_LD_W2;
            end
            S_LD_W2: begin
                o_mat_ctl.wr_en = 1'b1;
                o_mat_wr_addr   = {r_v, r_u};
                o_mat_wr_data   = sat_add32(i_mat_rd_data, DMF_RES_W'(r_c));
                n_state         = r_last ? S_START : S_IDLE;
            end
            S_START: begin
                n_flow  = '0;
                n_state = ends_ok ? S_PHASE : S_DONE;
            end
            // A new phase seeds the level search with the source.
            S_PHASE: begin
                n_lv        = '0;
                n_lv[src_v] = 1'b1;
                lev_we      = 1'b1;
                lev_wa      = src_v;
                lev_wd      = '0;
                q_we        = 1'b1;
                q_wa        = '0;
                q_wd        = {LW'(0), src_v};
                n_head      = '0;
                n_tail      = LW'(1);
                n_state     = S_BFS_POP;
            end
            S_BFS_POP: begin
                if (r_head < r_tail) begin
                    q_ra    = r_head[VW-1:0];
                    n_head  = r_head + LW'(1);
                    n_state = S_BFS_U;
                end else if (r_lv[snk_v]) begin
                    n_depth = '0;
                    n_cu    = src_v;
                    n_bn    = DMF_BOTTLENECK_START;
                    n_inc   = 1'b0;
                    n_nnv   = '0;
                    stk_we  = 1'b1;
                    stk_wa  = '0;
                    stk_wd  = src_v;
                    bn_we   = 1'b1;
                    bn_wa   = '0;
                    bn_wd   = DMF_BOTTLENECK_START;
                    n_state = S_DFS_TOP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BFS_U: begin
                n_bu    = r_q_rd[VW-1:0];
                n_blev  = r_q_rd[QW-1:VW];
                n_scan  = '0;
                n_state = S_BFS_SCAN;
            end
            S_BFS_SCAN, S_BFS_DRN: begin
                // Issue the next row read while the previous one is examined.
                if (r_state == S_BFS_SCAN) begin
                    o_mat_ctl.rd_en = 1'b1;
                    o_mat_rd_addr   = {r_bu, r_scan[VW-1:0]};
                    n_pv            = 1'b1;
                    n_pvv           = r_scan[VW-1:0];
                    n_scan          = r_scan + LW'(1);
                    n_state         = (r_scan == VC_M1) ? S_BFS_DRN : S_BFS_SCAN;
                end else begin
                    n_state = S_BFS_POP;
                end
                if (r_pv && !r_lv[r_pvv] && (i_mat_rd_data != '0) && (r_tail < VC_L)) begin
                    n_lv[r_pvv] = 1'b1;
                    lev_we      = 1'b1;
                    lev_wa      = r_pvv;
                    lev_wd      = r_blev + LW'(1);
                    q_we        = 1'b1;
                    q_wa        = r_tail[VW-1:0];
                    q_wd        = {r_blev + LW'(1), r_pvv};
                    n_tail      = r_tail + LW'(1);
                end
            end
            S_DFS_TOP: begin
                if (!r_inc && (r_cu == snk_v)) begin
                    n_ai    = '0;
                    n_a     = src_v;
                    n_state = S_AUG_RD;
                end else begin
                    nn_ra   = r_cu;
                    n_state = S_DFS_NN;
                end
            end
            S_DFS_NN: begin
                n_ptr   = nn_start;
                n_inc   = 1'b0;
                n_state = S_DFS_SCAN;
            end
            S_DFS_SCAN: begin
                if (r_ptr < VC_L) begin
                    o_mat_ctl.rd_en = 1'b1;
                    o_mat_rd_addr   = {r_cu, ptr_v};
                    lev_ra          = ptr_v;
                    n_state         = S_DFS_CHK;
                end else begin
                    retreat = 1'b1;
                end
            end
            S_DFS_CHK: begin
                if (adm && ((LW'(r_depth) + LW'(1)) < VC_L)) begin
                    // Advance along an admissible edge.
                    nn_we        = 1'b1;
                    nn_wa        = r_cu;
                    nn_wd        = r_ptr;
                    n_nnv[r_cu]  = 1'b1;
                    stk_we       = 1'b1;
                    stk_wa       = r_depth + VW'(1);
                    stk_wd       = ptr_v;
                    bn_we        = 1'b1;
                    bn_wa        = r_depth + VW'(1);
                    bn_wd        = cand_bn;
                    n_depth      = r_depth + VW'(1);
                    n_cu         = ptr_v;
                    n_bn         = cand_bn;
                    n_state      = S_DFS_TOP;
                end else if (adm) begin
                    retreat = 1'b1;
                end else begin
                    n_ptr   = r_ptr + LW'(1);
                    n_state = S_DFS_SCAN;
                end
            end
            S_DFS_POP: begin
                n_cu    = r_stk_rd;
                n_bn    = r_bn_rd;
                n_inc   = 1'b1;
                n_state = S_DFS_TOP;
            end
            S_AUG_RD: begin
                if (r_ai == r_depth) begin
                    n_flow  = flow_sum[DMF_FLOW_W] ? DMF_TOTAL_MAX
                                                   : flow_sum[DMF_FLOW_W-1:0];
                    n_depth = '0;
                    n_cu    = src_v;
                    n_bn    = DMF_BOTTLENECK_START;
                    n_inc   = 1'b0;
                    n_state = S_DFS_TOP;
                end else begin
                    stk_ra  = r_ai + VW'(1);
                    n_state = S_AUG_B;
                end
            end
            S_AUG_B: begin
                n_b             = r_stk_rd;
                o_mat_ctl.rd_en = 1'b1;
                o_mat_rd_addr   = {r_a, r_stk_rd};
                n_state         = S_AUG_W1;
            end
            S_AUG_W1: begin
                o_mat_ctl.wr_en = 1'b1;
                o_mat_wr_addr   = {r_a, r_b};
                o_mat_wr_data   = i_mat_rd_data - r_bn;
                n_state         = S_AUG_R2;
            end
            S_AUG_R2: begin
                o_mat_ctl.rd_en = 1'b1;
                o_mat_rd_addr   = {r_b, r_a};
                n_state         = S_AUG_W2;
            end
            S_AUG_W2: begin
                o_mat_ctl.wr_en = 1'b1;
                o_mat_wr_addr   = {r_b, r_a};
                o_mat_wr_data   = sat_add32(i_mat_rd_data, r_bn);
                n_a             = r_b;
                n_ai            = r_ai + VW'(1);
                n_state         = S_AUG_RD;
            end
            S_DONE: begin
                // Hand the total over once the result register is free.
                if (!r_oval) begin
                    n_oval  = 1'b1;
                    n_odata = r_flow;
                    n_clr   = '0;
                    n_state = S_CLR;
                end
            end
            default: begin
                n_state = S_CLR;
                n_clr   = '0;
            end
        endcase

        // Dead end: save the pointer and step back one vertex, or start a new phase at the source.
        if (retreat) begin
            nn_we       = 1'b1;
            nn_wa       = r_cu;
            nn_wd       = r_ptr;
            n_nnv[r_cu] = 1'b1;
            if (r_depth == '0) begin
                n_state = S_PHASE;
            end else begin
                n_depth = r_depth - VW'(1);
                stk_ra  = r_depth - VW'(1);
                bn_ra   = r_depth - VW'(1);
                n_state = S_DFS_POP;
            end
        end
    end

    // Control registers; reset starts a clearing pass over the matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_oval  <= 1'b0;
            r_pv    <= 1'b0;
            r_inc   <= 1'b0;
            r_lv    <= '0;
            r_nnv   <= '0;
            r_flow  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_oval  <= n_oval;
            r_pv    <= n_pv;
            r_inc   <= n_inc;
            r_lv    <= n_lv;
            r_nnv   <= n_nnv;
            r_flow  <= n_flow;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_u <= n_u; r_v <= n_v; r_c <= n_c; r_last <= n_last; r_inr <= n_inr;
        r_head <= n_head; r_tail <= n_tail; r_scan <= n_scan; r_bu <= n_bu;
        r_pvv <= n_pvv; r_blev <= n_blev; r_depth <= n_depth; r_cu <= n_cu;
        r_bn <= n_bn; r_ptr <= n_ptr; r_ai <= n_ai; r_a <= n_a; r_b <= n_b;
        r_odata <= n_odata;
    end

    // Scratch memories.
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[q_wa] <= q_wd;
        end
        if (lev_we) begin
            r_lev_mem[lev_wa] <= lev_wd;
        end
        if (nn_we) begin
            r_nn_mem[nn_wa] <= nn_wd;
        end
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        if (bn_we) begin
            r_bn_mem[bn_wa] <= bn_wd;
        end
        r_q_rd   <= r_q_mem[q_ra];
        r_lev_rd <= r_lev_mem[lev_ra];
        r_nn_rd  <= r_nn_mem[nn_ra];
        r_stk_rd <= r_stk_mem[stk_ra];
        r_bn_rd  <= r_bn_mem[bn_ra];
    end

endmodule

// ===== sv/dmf_checker.sv =====
// Port-level checks of the max flow engine, bound to the top level.
`timescale 1ns / 1ps
`include "dinic_max_flow_engine_macros.svh"
module dmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A waiting result stays offered.
    `DMF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result withdrawn while stalled")

    // A waiting result keeps its value.
    `DMF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

    // After an edge transaction the block is busy updating the matrix.
    `DMF_ASSERT_NEXT(a_busy_after_edge, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "edge taken while the previous one is loading")

    // An edge that is not last never produces a result right away.
    `DMF_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tlast, !$rose(m_axis_tvalid), "result without a last edge")

    // Reset empties the result register and leaves the block not ready.
    `DMF_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !m_axis_tvalid && !s_axis_tready, "reset left a result or readiness")

endmodule

bind dinic_max_flow_engine dmf_checker u_dmf_checker (.*);
